[hdl/bebm_pkg.sv]
// Package for the battery energy balance meter.
// Shared widths, reset values, register indexes and stage types.
// No dependencies.
package bebm_pkg;

  localparam int ACC_WIDTH_DEF = 48;   // default accumulator width
  localparam int FIELD_WIDTH   = 48;   // width of energy fields on the result
  localparam int VOLT_WIDTH    = 12;
  localparam int CUR_WIDTH     = 16;
  localparam int OFFS_WIDTH    = 17;
  localparam int PROD_WIDTH    = VOLT_WIDTH + CUR_WIDTH;
  localparam int CNT_WIDTH     = 32;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 48;
  localparam int IN_TDATA_WIDTH  = 32;
  localparam int OUT_TDATA_WIDTH = 120;

  localparam logic [15:0] ZERO_OFFSET_RST = 16'd32810;
  localparam logic [15:0] DEAD_BAND_RST   = 16'd25;
  localparam logic [47:0] DISCH_THR_RST   = 48'd46853473745;
  localparam logic [47:0] EMPTY_THR_RST   = 48'd130149;
  localparam logic [31:0] PERIOD_RST      = 32'd14400;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ZERO_OFFSET = 3'd0,
    REG_DEAD_BAND   = 3'd1,
    REG_DISCH_THR   = 3'd2,
    REG_EMPTY_THR   = 3'd3,
    REG_PERIOD      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] zero_offset;
    logic [15:0] dead_band;
    logic [47:0] discharge_threshold;
    logic [47:0] empty_threshold;
    logic [31:0] period_samples;
  } cfg_t;

  // one sample after offset removal and multiply
  typedef struct packed {
    logic                         to_out;   // current above offset, outside dead band
    logic                         to_in;    // current below offset, outside dead band
    logic [PROD_WIDTH-1:0]        product;  // voltage * |offset|
    logic signed [OFFS_WIDTH-1:0] offs;
  } prod_item_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0]       energy_out;
    logic [FIELD_WIDTH-1:0]       energy_in;
    logic                         discharging;
    logic signed [OFFS_WIDTH-1:0] current_offset;
    logic                         period_elapsed;
  } result_t;

endpackage

[hdl/bebm_cfg.sv]
// Configuration register file for the battery energy balance meter.
// Depends on bebm_pkg.
module bebm_cfg (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [bebm_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
  input  logic [bebm_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
  output bebm_pkg::cfg_t                          cfg
);
  import bebm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_offset         <= ZERO_OFFSET_RST;
      cfg.dead_band           <= DEAD_BAND_RST;
      cfg.discharge_threshold <= DISCH_THR_RST;
      cfg.empty_threshold     <= EMPTY_THR_RST;
      cfg.period_samples      <= PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ZERO_OFFSET: cfg.zero_offset         <= cfg_data[15:0];
        REG_DEAD_BAND:   cfg.dead_band           <= cfg_data[15:0];
        REG_DISCH_THR:   cfg.discharge_threshold <= cfg_data[47:0];
        REG_EMPTY_THR:   cfg.empty_threshold     <= cfg_data[47:0];
        REG_PERIOD:      cfg.period_samples      <= cfg_data[31:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

[hdl/bebm_front.sv]
// Offset removal, dead band and voltage * current multiply.
// Depends on bebm_pkg.
module bebm_front (
  input  logic [bebm_pkg::VOLT_WIDTH-1:0] voltage_code,
  input  logic [bebm_pkg::CUR_WIDTH-1:0]  current_code,
  input  logic [15:0]                     zero_offset,
  input  logic [15:0]                     dead_band,
  output bebm_pkg::prod_item_t            item
);
  import bebm_pkg::*;

  logic                  above;
  logic                  below;
  logic [CUR_WIDTH-1:0]  mag;
  logic                  outside;
  logic [OFFS_WIDTH-1:0] mag_ext;

  always_comb begin
    above   = current_code > zero_offset;
    below   = current_code < zero_offset;
    mag     = above ? (current_code - zero_offset) : (zero_offset - current_code);
    outside = mag > dead_band;
    mag_ext = {1'b0, mag};

    item.to_out  = above && outside;
    item.to_in   = below && outside;
    item.product = {{CUR_WIDTH{1'b0}}, voltage_code} * {{VOLT_WIDTH{1'b0}}, mag};
    if (item.to_out) begin
      item.offs = mag_ext;
    end else if (item.to_in) begin
      item.offs = -mag_ext;
    end else begin
      item.offs = '0;
    end
  end

endmodule

[hdl/bebm_accum.sv]
// Energy accumulators, discharge flag and idle period counter.
// Depends on bebm_pkg.
module bebm_accum #(
  parameter int ACC_WIDTH = bebm_pkg::ACC_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,     // consume item this cycle
  input  bebm_pkg::prod_item_t item,
  input  bebm_pkg::cfg_t       cfg,
  output bebm_pkg::result_t    res       // result if item is consumed
);
  import bebm_pkg::*;

  localparam int SW = ACC_WIDTH + 1;
  localparam int CW = (ACC_WIDTH > FIELD_WIDTH) ? ACC_WIDTH : FIELD_WIDTH;

  logic [ACC_WIDTH-1:0] out_energy_acc, out_energy_acc_next;
  logic [ACC_WIDTH-1:0] in_energy_acc, in_energy_acc_next;
  logic                 discharge_flag, discharge_flag_next;
  logic [CNT_WIDTH-1:0] sample_count, sample_count_next;

  logic [SW-1:0]        sum;
  logic [ACC_WIDTH-1:0] o1, i1, i2;
  logic                 f2;
  logic [CNT_WIDTH-1:0] cnt1;
  logic                 elapsed;
  logic [CW-1:0]        o_ext, i_ext;

  always_comb begin
    cnt1 = (sample_count == '1) ? sample_count : sample_count + 1'b1;

    // saturating add into whichever side the current points to
    sum = {1'b0, (item.to_out ? out_energy_acc : in_energy_acc)} + SW'(item.product);
    o1  = out_energy_acc;
    i1  = in_energy_acc;
    if (item.to_out) begin
      o1 = sum[SW-1] ? '1 : sum[ACC_WIDTH-1:0];
    end else if (item.to_in) begin
      i1 = sum[SW-1] ? '1 : sum[ACC_WIDTH-1:0];
    end

    // start of discharge clears incoming energy
    f2 = discharge_flag;
    i2 = i1;
    if (!discharge_flag && (CW'(o1) > CW'(cfg.discharge_threshold))) begin
      f2 = 1'b1;
      i2 = '0;
    end

    // end of discharge clears outgoing energy
    discharge_flag_next = f2;
    out_energy_acc_next = o1;
    if (f2 && (i2 > o1)) begin
      discharge_flag_next = 1'b0;
      out_energy_acc_next = '0;
    end

    // idle and empty past the period: clear incoming energy
    in_energy_acc_next = i2;
    sample_count_next  = cnt1;
    elapsed            = 1'b0;
    if (!discharge_flag_next && (CW'(out_energy_acc_next) < CW'(cfg.empty_threshold)) &&
        (cnt1 > cfg.period_samples)) begin
      in_energy_acc_next = '0;
      sample_count_next  = '0;
      elapsed            = 1'b1;
    end

    o_ext = CW'(out_energy_acc_next);
    i_ext = CW'(in_energy_acc_next);
    res.energy_out     = o_ext[FIELD_WIDTH-1:0];
    res.energy_in      = i_ext[FIELD_WIDTH-1:0];
    res.discharging    = discharge_flag_next;
    res.current_offset = item.offs;
    res.period_elapsed = elapsed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_energy_acc <= '0;
      in_energy_acc  <= '0;
      discharge_flag <= 1'b0;
      sample_count   <= '0;
    end else if (step) begin
      out_energy_acc <= out_energy_acc_next;
      in_energy_acc  <= in_energy_acc_next;
      discharge_flag <= discharge_flag_next;
      sample_count   <= sample_count_next;
    end
  end

endmodule

[hdl/battery_energy_balance_meter.sv]
// Top level of the battery energy balance meter.
// Depends on bebm_pkg, bebm_cfg, bebm_front, bebm_accum.
//
// Takes one voltage/current sample pair per transfer and returns one result
// per sample: both energy accumulators, the discharge flag, the signed current
// offset and the idle-period flag. One transfer can be accepted every clock
// while m_tready keeps results moving. A sample passes three registers
// (input register, product register, result register). The input register
// loads on the input transfer edge; the sample then moves on into the product
// register and the result register, which drives m_tvalid. The multiply sits
// between the first two registers; the saturating add, the threshold compares
// and the state update sit between the product and result registers, where
// the accumulator state loops back. Each stage moves when the stage after it
// is empty or moving, so a result waiting on m_tready does not block inputs
// while earlier stages have room. Configuration registers are written
// through cfg_we/cfg_index/cfg_data and should only change while no sample is
// in flight. Energies are raw units of voltage code times current code; the
// accumulators saturate at 2^ACC_WIDTH-1 and the result fields carry their
// low 48 bits.
module battery_energy_balance_meter #(
  parameter int ACC_WIDTH = bebm_pkg::ACC_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // input samples
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [bebm_pkg::IN_TDATA_WIDTH-1:0]     s_tdata,  // [11:0] voltage_code,
                                                            // [27:12] current_code
  // results
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [bebm_pkg::OUT_TDATA_WIDTH-1:0]    m_tdata,  // [47:0] energy_out,
                                                            // [95:48] energy_in,
                                                            // [96] discharging,
                                                            // [113:97] current_offset,
                                                            // [114] period_elapsed
  // configuration writes
  input  logic                                    cfg_we,
  input  logic [bebm_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
  input  logic [bebm_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);
  import bebm_pkg::*;

  cfg_t cfg;

  // stage 1: input register
  logic                  v1;
  logic [VOLT_WIDTH-1:0] voltage_code;
  logic [CUR_WIDTH-1:0]  current_code;
  // stage 2: product register
  logic                  v2;
  prod_item_t            item_d, item;
  // stage 3: result register
  logic                  v3;
  result_t               res_d, res;

  logic ready1, ready2, ready3;

  // a stage can load when it is empty or its content moves on
  assign ready3   = !v3 || m_tready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;

  bebm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bebm_front u_front (
    .voltage_code (voltage_code),
    .current_code (current_code),
    .zero_offset  (cfg.zero_offset),
    .dead_band    (cfg.dead_band),
    .item         (item_d)
  );

  // state advances only when the sample in stage 2 moves into the result register
  bebm_accum #(.ACC_WIDTH(ACC_WIDTH)) u_accum (
    .clk  (clk),
    .rst  (rst),
    .step (v2 && ready3),
    .item (item),
    .cfg  (cfg),
    .res  (res_d)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= s_tvalid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && ready1) begin
      voltage_code <= s_tdata[VOLT_WIDTH-1:0];
      current_code <= s_tdata[VOLT_WIDTH+CUR_WIDTH-1:VOLT_WIDTH];
    end
    if (v1 && ready2) begin
      item <= item_d;
    end
    if (v2 && ready3) begin
      res <= res_d;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {5'b0, res.period_elapsed, res.current_offset, res.discharging,
                     res.energy_in, res.energy_out};

endmodule
